// ===== design/wma_pkg.sv =====
// wma_pkg: shared widths, configuration constants and payload structs
// for the windowed moving average block.
// Depends on nothing; imported by windowed_moving_average.
`default_nettype none

package wma_pkg;

    // sample and result widths, fixed by the payload format
    localparam int SAMPLE_BITS   = 16;
    localparam int WINDOW_BITS   = 7;
    localparam int MAX_WINDOW    = 64;
    localparam int WINDOW_RESET  = 64;

    // one input transfer: a sample or a clear request
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clear;
    } sample_item_t;

    // one output transfer: average and current fill count
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [WINDOW_BITS-1:0]        fill_count;
    } result_item_t;

endpackage

`default_nettype wire

// ===== design/windowed_moving_average.sv =====
// windowed_moving_average: ring-buffer moving average with a bit-serial
// restoring divider for the sum / count step.
// Depends on wma_pkg (widths, payload structs, reset constants).
`default_nettype none

// Usage
//   sample channel: sample_valid / sample_stall / sample_item. Each transfer
//   carries one Q8.8 sample or a clear request. Clear empties the window.
//   result channel: result_valid / result_stall / result_item. Every input
//   transfer yields exactly one result: the average (truncated toward zero,
//   0 when empty) and the fill count.
//   window_we / window_data write the window length (0 acts as 1, values
//   above MAX_WINDOW act as MAX_WINDOW); change it together with a clear.
// Timing
//   a sample passes through an update state, the divide state and an output
//   state; no new sample is taken until the block is back in idle. A clear
//   goes straight to the output state. The bit-serial divider makes one
//   quotient bit per cycle over the SUM_W bits of the sum.
// Reset and stall
//   reset empties the window and sets the window length to 64. A finished
//   result waits in the output register while the next item is worked on;
//   the block holds its next result until the receiver takes the first.
module windowed_moving_average #(
    parameter int MAX_WINDOW = wma_pkg::MAX_WINDOW
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             sample_valid,
    output      logic                             sample_stall,
    input  wire wma_pkg::sample_item_t            sample_item,
    output      logic                             result_valid,
    input  wire logic                             result_stall,
    output      wma_pkg::result_item_t            result_item,
    input  wire logic                             window_we,
    input  wire logic [wma_pkg::WINDOW_BITS-1:0]  window_data
);

    import wma_pkg::*;

    // the window register cannot name more than WIN_LIMIT entries
    localparam int WIN_LIMIT  = (2 ** WINDOW_BITS) - 1;
    localparam int EFF_MAX    = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;
    localparam int POS_W      = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam int CNT_W      = $clog2(EFF_MAX + 1);
    localparam int SUM_W      = SAMPLE_BITS + $clog2(EFF_MAX);
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // control state
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [WINDOW_BITS-1:0]   window_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [DIV_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;

    // datapath registers
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          append_reg, append_next;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic [SUM_W-1:0]              quo_reg, quo_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic                          neg_reg, neg_next;
    result_item_t                  out_data_reg, out_data_next;

    // ring store, read through a registered port
    logic signed [SAMPLE_BITS-1:0] ring_mem [EFF_MAX];

    // combinational helpers
    logic [CNT_W-1:0]         win_eff;
    logic [CNT_W-1:0]         pos_inc;
    logic [POS_W-1:0]         pos_wrap;
    logic                     accept;
    logic                     out_free;
    logic signed [SUM_W-1:0]  sum_upd;
    logic [CNT_W:0]           rem_shift;
    logic [CNT_W:0]           rem_diff;
    logic                     rem_fits;
    logic [SAMPLE_BITS-1:0]   quo_low;

    // effective window length with saturation
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (window_reg > WINDOW_BITS'(EFF_MAX))
        begin
            win_eff = CNT_W'(EFF_MAX);
        end
        else
        begin
            win_eff = CNT_W'(window_reg);
        end
    end

    // next ring position once the window is full
    assign pos_inc  = CNT_W'(pos_reg) + CNT_W'(1);
    assign pos_wrap = (pos_inc >= win_eff) ? '0 : pos_inc[POS_W-1:0];

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !out_valid_reg || !result_stall;

    // running sum update: add new sample, drop the oldest when full
    assign sum_upd = sum_reg + SUM_W'(sample_reg)
                     - (append_reg ? '0 : SUM_W'(rd_data_reg));

    // one restoring division step
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, count_reg};
    assign rem_fits  = (rem_shift >= {1'b0, count_reg});
    assign quo_low   = quo_reg[SAMPLE_BITS-1:0];

    // sequencer and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        append_next    = append_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        out_data_next  = out_data_reg;

        // result register drains on a transfer
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample_item.clear)
                    begin
                        count_next = '0;
                        pos_next   = '0;
                        sum_next   = '0;
                        quo_next   = '0;
                        neg_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sample_next = sample_item.sample;
                        if (count_reg < win_eff)
                        begin
                            append_next = 1'b1;
                            pos_next    = count_reg[POS_W-1:0];
                            count_next  = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            append_next = 1'b0;
                            pos_next    = pos_wrap;
                        end
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                sum_next     = sum_upd;
                neg_next     = sum_upd[SUM_W-1];
                quo_next     = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
                rem_next     = '0;
                bit_cnt_next = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                rem_next = rem_fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], rem_fits};
                if (bit_cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + DIV_CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next.average    = neg_reg ? -quo_low : quo_low;
                    out_data_next.fill_count = WINDOW_BITS'(count_reg);
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            window_reg    <= WINDOW_BITS'(WINDOW_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
            if (window_we)
            begin
                window_reg <= window_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        append_reg   <= append_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    // ring store write and registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[pos_wrap];
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_data_reg;

endmodule

`default_nettype wire
